[src/apparent_temperature_heat_alarm_defines.svh]
// ----------------------------------------------------------------------------
// apparent temperature heat alarm assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef APPARENT_TEMPERATURE_HEAT_ALARM_DEFINES_SVH
`define APPARENT_TEMPERATURE_HEAT_ALARM_DEFINES_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ATHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen
`define ATHA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ATHA_ASSERT(lbl, prop, msg)
`define ATHA_NEVER(lbl, cond, msg)
`endif

`endif

[src/atha_pkg.sv]
// ----------------------------------------------------------------------------
// atha_pkg
// shared types, constants and table function of the heat alarm
// ----------------------------------------------------------------------------
package atha_pkg;

    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic [13:0]        humidity_centi;
        logic               occupied;
        logic               manual_override;
        logic               alarm_clear;
    } sample_t;

    typedef struct packed {
        logic signed [15:0] apparent_temp_centi;
        logic [15:0]        vapour_pressure_centi;
        logic               alarm_fired;
        logic               alarm_active;
    } result_t;

    // shared divider geometry
    localparam int DVD_W = 36;
    localparam int DSR_W = 17;
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] DIV_STEPS = 6'd36;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

    // register indexes
    localparam logic CFG_COMFORT = 1'b0;
    localparam logic CFG_DANGER  = 1'b1;

    // fixed point constants
    localparam logic [20:0] EXP2_COEF_Q16 = 21'd1632852;
    localparam logic [63:0] LN2_Q30       = 64'd744261118;
    localparam logic [63:0] ONE_Q30       = 64'd1073741824;
    localparam logic [15:0] D_BASE        = 16'd23770;
    localparam logic [12:0] MAGNUS_MILLI  = 13'd6105;
    localparam logic [16:0] E_DIV         = 17'd100000;
    localparam logic [44:0] E_HALF        = 45'd50000;
    localparam logic [44:0] E_SAT_LIMIT   = 45'd6553600000;
    localparam logic [16:0] AT_DIV        = 17'd100;
    localparam logic [35:0] AT_HALF       = 36'd50;
    localparam logic [35:0] Z_LIMIT       = 36'd1048576;

    // 2^(k/N) in Q30 from the exp series at y = k*ln2/N
    function automatic logic [31:0] exp_series(input logic [63:0] y);
        logic [63:0] sum;
        logic [63:0] term;
        logic        done;
        sum  = ONE_Q30;
        term = ONE_Q30;
        done = 1'b0;
        for (int n = 1; n < 64; n++) begin
            if (!done) begin
                term = ((term * y) >> 30) / 64'(n);
                if (term == 64'd0)
                    done = 1'b1;
                else
                    sum = sum + term;
            end
        end
        return sum[31:0];
    endfunction

endpackage

[src/atha_div.sv]
// ----------------------------------------------------------------------------
// atha_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "apparent_temperature_heat_alarm_defines.svh"

module atha_div
    import atha_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W:0]   trial;
    logic             fit;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fit   = trial >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_STEPS;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= fit ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], fit};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    `ATHA_NEVER(a_start_while_busy, req.start && busy_reg, "divider restarted while busy")
    `ATHA_ASSERT(a_done_after_busy, rsp.done |-> $past(busy_reg), "done without a pass")
    `ATHA_ASSERT(a_cnt_live, busy_reg |-> (cnt_reg != '0), "busy with empty step count")

endmodule

[src/apparent_temperature_heat_alarm.sv]
// ----------------------------------------------------------------------------
// apparent_temperature_heat_alarm
// magnus vapour pressure, steadman apparent temperature and latched heat alarm
// ----------------------------------------------------------------------------
// sequence: exponent, vapour pressure and apparent temperature divider passes; the
//   pressure pass is skipped when the vapour pressure saturates
// flow: one sample at a time, next request taken once the result is staged; staging
//   waits while the previous result is still held by result_stall
// reset: alarm latch off, comfort threshold 3500, danger threshold 4000, idle
`include "apparent_temperature_heat_alarm_defines.svh"

module apparent_temperature_heat_alarm
    import atha_pkg::*;
#(
    parameter int EXP_TABLE_ENTRIES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    // table index width covers entries 0..N
    localparam int NW = $clog2(EXP_TABLE_ENTRIES + 1);
    localparam int PW = 16 + NW;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ZSTART, S_ZWAIT, S_PMUL, S_TAB, S_INTERP, S_M,
        S_PROD, S_SHIFT, S_EWAIT, S_ATNUM, S_AWAIT, S_FINISH
    } state_t;

    // constant 2^(k/N) table, built at elaboration
    logic [31:0] exp_tab [EXP_TABLE_ENTRIES+1];

    for (genvar k = 0; k <= EXP_TABLE_ENTRIES; k++)
    begin : g_tab
        localparam logic [63:0] Y = (64'(k) * LN2_Q30 + 64'(EXP_TABLE_ENTRIES / 2))
                                    / 64'(EXP_TABLE_ENTRIES);
        assign exp_tab[k] = exp_series(Y);
    end

    // control state
    state_t             state_reg;
    logic               result_valid_reg;
    logic               alarm_latch_reg;
    logic signed [15:0] comfort_reg;
    logic signed [15:0] danger_reg;
    logic               div_start_reg;

    // sample and datapath registers
    logic signed [14:0] tc_reg;
    logic [13:0]        h_reg;
    logic               occ_reg;
    logic               man_reg;
    logic signed [36:0] prodz_reg;
    logic [26:0]        hm_reg;
    logic [15:0]        d_reg;
    logic [15:0]        zu_reg;
    logic [5:0]         s_reg;
    logic [PW-1:0]      p_reg;
    logic [31:0]        lo_reg;
    logic [31:0]        hi_reg;
    logic [47:0]        fp_reg;
    logic [31:0]        m_reg;
    logic [58:0]        prod_reg;
    logic [15:0]        e_reg;
    logic               at_neg_reg;
    logic signed [15:0] at_reg;
    logic [DVD_W-1:0]   dvd_reg;
    logic [DSR_W-1:0]   dsr_reg;
    result_t            result_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // combinational helpers
    logic [35:0]        zmag;
    logic [20:0]        zu_calc;
    logic [NW-1:0]      idx;
    logic [44:0]        x_calc;
    logic signed [23:0] atn;
    logic [22:0]        atmag;
    logic signed [15:0] at_calc;
    logic               fired;
    logic               accept;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = (state_reg != S_IDLE);

    always_comb
    begin
        // rounded exponent magnitude numerator
        zmag = 36'(prodz_reg[36] ? -prodz_reg : prodz_reg);
        // clamp the signed quotient and bias by 16 in the integer part
        if (tc_reg[14])
            zu_calc = (div_rsp.quotient >= Z_LIMIT) ? 21'd0
                                                     : 21'(Z_LIMIT - div_rsp.quotient);
        else
            zu_calc = (div_rsp.quotient >= Z_LIMIT - 36'd1) ? 21'h1FFFFF
                                                             : 21'(Z_LIMIT + div_rsp.quotient);
        idx     = p_reg[PW-1:16];
        // pressure numerator after the power-of-two scale
        x_calc  = 45'(prod_reg >> s_reg) + E_HALF;
        atn     = 24'(tc_reg) * 24'sd107 + $signed(24'(e_reg) * 24'd20) - 24'sd27000;
        atmag   = 23'(atn[23] ? -atn : atn);
        at_calc = at_neg_reg ? -$signed(div_rsp.quotient[15:0])
                             : $signed(div_rsp.quotient[15:0]);
        // judge against the latch already cleared at request time
        fired   = occ_reg && !alarm_latch_reg &&
                  (((at_reg >= comfort_reg) && !man_reg) || (at_reg >= danger_reg));
    end

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = dvd_reg;
    assign div_req.divisor  = dsr_reg;

    atha_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer, latch, thresholds and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            alarm_latch_reg  <= 1'b0;
            comfort_reg      <= 16'sd3500;
            danger_reg       <= 16'sd4000;
            div_start_reg    <= 1'b0;
        end
        else
        begin
            // divider kicked off for exponent, unsaturated pressure and apparent temperature
            div_start_reg <= (state_reg == S_ZSTART) || (state_reg == S_ATNUM) ||
                             ((state_reg == S_SHIFT) && (x_calc < E_SAT_LIMIT));
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_COMFORT: comfort_reg <= cfg_data;
                    CFG_DANGER:  danger_reg  <= cfg_data;
                    default:     ;
                endcase
            end
            // result taken by the downstream side, unless a new one is staged now
            if (result_valid_reg && !result_stall && (state_reg != S_FINISH))
                result_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        // clear acts before the sample is judged
                        if (sample.alarm_clear)
                            alarm_latch_reg <= 1'b0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:    state_reg <= S_ZSTART;
                S_ZSTART: state_reg <= S_ZWAIT;
                S_ZWAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_PMUL;
                end
                S_PMUL:   state_reg <= S_TAB;
                S_TAB:    state_reg <= S_INTERP;
                S_INTERP: state_reg <= S_M;
                S_M:      state_reg <= S_PROD;
                S_PROD:   state_reg <= S_SHIFT;
                S_SHIFT:
                begin
                    // saturated pressure skips the divider
                    if (x_calc >= E_SAT_LIMIT)
                        state_reg <= S_ATNUM;
                    else
                        state_reg <= S_EWAIT;
                end
                S_EWAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_ATNUM;
                end
                S_ATNUM:  state_reg <= S_AWAIT;
                S_AWAIT:
                begin
                    if (div_rsp.done)
                        state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // wait for a free output slot
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_valid_reg <= 1'b1;
                        if (fired)
                            alarm_latch_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath, one step per state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tc_reg  <= sample.temp_centi;
                    h_reg   <= sample.humidity_centi;
                    occ_reg <= sample.occupied;
                    man_reg <= sample.manual_override;
                end
            end
            S_MUL:
            begin
                prodz_reg <= 37'(tc_reg) * $signed(37'(EXP2_COEF_Q16));
                hm_reg    <= 27'(h_reg) * 27'(MAGNUS_MILLI);
                d_reg     <= D_BASE + 16'(tc_reg);
            end
            S_ZSTART:
            begin
                dvd_reg <= zmag + 36'(d_reg >> 1);
                dsr_reg <= DSR_W'(d_reg);
            end
            S_ZWAIT:
            begin
                if (div_rsp.done)
                begin
                    zu_reg <= zu_calc[15:0];
                    s_reg  <= 6'd46 - {1'b0, zu_calc[20:16]};
                end
            end
            S_PMUL:   p_reg <= PW'(zu_reg) * PW'(EXP_TABLE_ENTRIES);
            S_TAB:
            begin
                lo_reg <= exp_tab[idx];
                hi_reg <= exp_tab[NW'(idx + 1'b1)];
            end
            S_INTERP:
                fp_reg <= (hi_reg > lo_reg) ? 48'(hi_reg - lo_reg) * 48'(p_reg[15:0]) : 48'd0;
            S_M:      m_reg <= lo_reg + 32'(fp_reg >> 16);
            S_PROD:   prod_reg <= 59'(hm_reg) * 59'(m_reg);
            S_SHIFT:
            begin
                if (x_calc >= E_SAT_LIMIT)
                    e_reg <= 16'hFFFF;
                dvd_reg <= x_calc[35:0];
                dsr_reg <= E_DIV;
            end
            S_EWAIT:
            begin
                if (div_rsp.done)
                    e_reg <= div_rsp.quotient[15:0];
            end
            S_ATNUM:
            begin
                at_neg_reg <= atn[23];
                dvd_reg    <= 36'(atmag) + AT_HALF;
                dsr_reg    <= AT_DIV;
            end
            S_AWAIT:
            begin
                if (div_rsp.done)
                    at_reg <= at_calc;
            end
            S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_reg.apparent_temp_centi   <= at_reg;
                    result_reg.vapour_pressure_centi <= e_reg;
                    result_reg.alarm_fired           <= fired;
                    result_reg.alarm_active          <= alarm_latch_reg || fired;
                end
            end
            default: ;
        endcase
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ATHA_ASSERT(a_fired_active, (result_valid && result.alarm_fired) |-> result.alarm_active,
                 "fired without active latch")
    `ATHA_ASSERT(a_latch_set_at_finish, $rose(alarm_latch_reg) |-> $past(state_reg == S_FINISH),
                 "latch set outside result staging")
    `ATHA_ASSERT(a_result_from_finish, $rose(result_valid_reg) |-> $past(state_reg == S_FINISH),
                 "result staged outside finish")

endmodule

[tb/sv/tb_apparent_temperature_heat_alarm.sv]
// ----------------------------------------------------------------------------
// tb_apparent_temperature_heat_alarm
// drives sensor sample requests with random gaps, predicts vapour pressure,
// apparent temperature and alarm latch in fixed point, checks every result
// ----------------------------------------------------------------------------
module tb_apparent_temperature_heat_alarm
    import atha_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_N     = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    apparent_temperature_heat_alarm #(.EXP_TABLE_ENTRIES(TABLE_N)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predictor state: thresholds, alarm latch, 2^(k/N) table in q30
    longint      comfort_lvl;
    longint      danger_lvl;
    bit          latch_model;
    longint      pow2_tab [TABLE_N+1];

    sample_t     pending_samples [$];
    result_t     expected_results [$];
    int          errors = 0;
    int          checked = 0;
    int          fired_count = 0;
    longint      cycles = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // exp series per entry, terms truncated until zero
    function automatic void build_pow2_table();
        longint unsigned y, sum, term;
        for (int k = 0; k <= TABLE_N; k++)
        begin
            y = (longint'(k) * 64'd744261118 + TABLE_N / 2) / TABLE_N;
            sum = 64'd1073741824;
            term = sum;
            for (int n = 1; n < 64; n++)
            begin
                term = ((term * y) >> 30) / n;
                if (term == 0)
                    break;
                sum += term;
            end
            pow2_tab[k] = longint'(sum);
        end
    endfunction

    // rounding divide, ties away from zero
    function automatic longint div_round_away(longint num, longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    // one sample through the fixed point path, updates the latch
    function automatic result_t heat_predict(sample_t s);
        result_t r;
        longint tc, h, z, zu, ex, f, p, idx, fr, lo, hi, m, e, at;
        longint unsigned prod, dv;
        tc = longint'(s.temp_centi);
        h  = longint'(s.humidity_centi);
        if (s.alarm_clear)
            latch_model = 1'b0;
        z = div_round_away(tc * 1632852, 23770 + tc);
        if (z < -1048576)
            z = -1048576;
        if (z > 1048575)
            z = 1048575;
        zu  = z + 1048576;
        ex  = (zu >> 16) - 16;
        f   = zu & 16'hFFFF;
        p   = f * TABLE_N;
        idx = p >> 16;
        fr  = p & 16'hFFFF;
        lo  = pow2_tab[idx];
        hi  = pow2_tab[idx+1];
        m   = lo + ((hi > lo) ? (((hi - lo) * fr) >> 16) : 0);
        prod = longint'(h) * 6105 * m;
        dv   = 64'd100000 << (30 - ex);
        e    = longint'((prod + dv / 2) / dv);
        if (e > 65535)
            e = 65535;
        at = div_round_away(107 * tc + 20 * e - 27000, 100);
        if (at > 32767)
            at = 32767;
        if (at < -32768)
            at = -32768;
        r.alarm_fired = 1'b0;
        if (s.occupied && !latch_model
            && ((at >= comfort_lvl && !s.manual_override) || at >= danger_lvl))
        begin
            latch_model   = 1'b1;
            r.alarm_fired = 1'b1;
        end
        r.apparent_temp_centi   = at[15:0];
        r.vapour_pressure_centi = e[15:0];
        r.alarm_active          = latch_model;
        return r;
    endfunction

    // mostly short gaps, a few long ones, sometimes none
    function automatic int gap_len();
        int c;
        c = $urandom_range(99);
        if (c < 45)
            return 0;
        if (c < 92)
            return $urandom_range(3, 1);
        return $urandom_range(150, 20);
    endfunction

    function automatic sample_t rand_sample(bit wild);
        sample_t s;
        if (wild)
            s = sample_t'($urandom);
        else
        begin
            s.temp_centi     = 15'($signed($urandom_range(12500)) - 4000);
            s.humidity_centi = 14'($urandom_range(10000));
            s.occupied       = ($urandom_range(9) < 8);
            s.manual_override = ($urandom_range(3) == 0);
            s.alarm_clear    = ($urandom_range(4) == 0);
        end
        return s;
    endfunction

    function automatic sample_t mk(int t, int h, bit occ, bit man, bit clr);
        sample_t s;
        s.temp_centi = 15'(t);
        s.humidity_centi = 14'(h);
        s.occupied = occ;
        s.manual_override = man;
        s.alarm_clear = clr;
        return s;
    endfunction

    // driver: requests leave the queue, gap inserted after each accept
    int drv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample       <= '0;
            drv_gap      = 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                expected_results.push_back(heat_predict(sample));
                drv_gap = gap_len();
            end
            if (!sample_valid || !sample_stall)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample_valid <= 1'b1;
                    sample       <= pending_samples.pop_front();
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each accepted result with the oldest expectation
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    errors++;
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    checked++;
                    fired_count += result.alarm_fired;
                    if (result.apparent_temp_centi !== want.apparent_temp_centi)
                    begin
                        $display("%0t: apparent_temp exp %0d got %0d", $time,
                                 want.apparent_temp_centi, result.apparent_temp_centi);
                        errors++;
                    end
                    if (result.vapour_pressure_centi !== want.vapour_pressure_centi)
                    begin
                        $display("%0t: vapour_pressure exp %0d got %0d", $time,
                                 want.vapour_pressure_centi, result.vapour_pressure_centi);
                        errors++;
                    end
                    if (result.alarm_fired !== want.alarm_fired)
                    begin
                        $display("%0t: alarm_fired exp %b got %b", $time,
                                 want.alarm_fired, result.alarm_fired);
                        errors++;
                    end
                    if (result.alarm_active !== want.alarm_active)
                    begin
                        $display("%0t: alarm_active exp %b got %b", $time,
                                 want.alarm_active, result.alarm_active);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                stall_left = gap_len();
                result_stall <= (stall_left > 0);
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // register write while idle, predictor follows
    task automatic write_threshold(logic idx, int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_COMFORT)
            comfort_lvl = longint'($signed(16'(value)));
        else
            danger_lvl = longint'($signed(16'(value)));
    endtask

    task automatic drain_results();
        wait (pending_samples.size() == 0 && !sample_valid
              && expected_results.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        int phase_cfg [5][2];
        comfort_lvl = 3500;
        danger_lvl = 4000;
        latch_model = 1'b0;
        build_pow2_table();
        cfg_we = 1'b0;
        cfg_index = CFG_COMFORT;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, clamp ends, manual override, clear and refire
        pending_samples.push_back(mk(-4000, 0, 1, 0, 0));
        pending_samples.push_back(mk(8500, 10000, 1, 0, 0));
        pending_samples.push_back(mk(8500, 10000, 1, 0, 0));      // already latched
        pending_samples.push_back(mk(8500, 10000, 1, 0, 1));      // clear then refire
        pending_samples.push_back(mk(3600, 5000, 1, 1, 1));       // override at danger level
        pending_samples.push_back(mk(5000, 9000, 1, 1, 1));       // danger under override
        pending_samples.push_back(mk(5000, 9000, 0, 0, 1));       // car empty
        pending_samples.push_back(mk(-16384, 16383, 1, 0, 1));    // raw field extremes
        pending_samples.push_back(mk(16383, 16383, 1, 1, 1));
        pending_samples.push_back(mk(-16384, 0, 0, 1, 0));
        pending_samples.push_back(mk(0, 10000, 1, 0, 1));
        pending_samples.push_back(mk(-1, 1, 1, 0, 0));
        pending_samples.push_back(mk(2500, 10000, 1, 0, 1));
        pending_samples.push_back(mk(-13000, 12000, 1, 0, 1));
        drain_results();

        // threshold settings, extremes included
        phase_cfg = '{'{-4600, -4600}, '{20400, 20400}, '{3000, 3800},
                      '{-32768, 32767}, '{3500, 4000}};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_threshold(CFG_COMFORT, phase_cfg[ph][0]);
            write_threshold(CFG_DANGER, phase_cfg[ph][1]);
            for (int n = 0; n < 88; n++)
                pending_samples.push_back(rand_sample($urandom_range(9) == 0));
            drain_results();
        end

        $display("checked %0d results over 5 threshold settings, %0d alarm firings",
                 checked, fired_count);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
